### hdl/rct_pkg.sv
// ---------------------------------------------------------------------------
// rct_pkg
// Shared sizes, status codes and the controller/datapath command and
// status bundles of the reference count table.
// ---------------------------------------------------------------------------
`default_nettype none

package rct_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;
    localparam int CNT_W       = 16;
    localparam int STATUS_W    = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // operation codes
    localparam logic OP_ADD     = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_COUNTED     = 3'd0,
        ST_FREED       = 3'd1,
        ST_ZERO_ID     = 3'd2,
        ST_FULL        = 3'd3,
        ST_NOT_TRACKED = 3'd4
    } t_status;

    // one table entry
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic    load;       // capture request fields
        logic    scan_step;  // issue next lookup read, compare previous
        logic    wr_inc;     // saturating increment of the matched slot
        logic    wr_dec;     // decrement of the matched slot
        logic    wr_new;     // append new entry with count one
        logic    rd_last;    // read the last live entry
        logic    wr_move;    // move last entry into the matched slot
        logic    emit;       // load the result register
        t_status emit_status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_id_zero;  // incoming id is zero
        logic is_release;  // captured operation is a release
        logic hit;         // lookup matched this cycle
        logic miss;        // lookup ran past the live entries
        logic full;        // every slot is live
        logic cnt_gt1;     // matched count above one
        logic out_free;    // result register can take a new result
    } t_stat;

endpackage

`default_nettype wire

### hdl/reference_count_table.sv
// ---------------------------------------------------------------------------
// reference_count_table
// Table of tracked object ids with 16-bit saturating reference counts.
// Adds append unknown ids, releases free an entry at count zero by moving
// the last live entry into its slot.
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   i_operation, i_object_id
//  result    out        o_out_valid / i_out_stall o_status, o_use_count
//
// A request walks the live entries: the lookup reads one entry per cycle from
// the entry memory until a hit or the end of the live entries. A free adds a
// read of the last live entry before the move. A zero id goes straight to the
// result. Reset clears the fill count but not the entry memory; no clearing
// pass is needed. A stalled result holds in the output register while the
// next request is already worked on.
// ---------------------------------------------------------------------------
`default_nettype none

module reference_count_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_operation,
    input  wire logic [rct_pkg::ID_W-1:0]      i_object_id,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [rct_pkg::STATUS_W-1:0]       o_status,
    output logic [rct_pkg::CNT_W-1:0]          o_use_count
);

    rct_pkg::t_cmd  cmd;
    rct_pkg::t_stat stat;

    // sequencer
    rct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // table storage and result register
    rct_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_operation (i_operation),
        .i_object_id (i_object_id),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_use_count (o_use_count)
    );

endmodule

`default_nettype wire

### hdl/rct_dpath.sv
// ---------------------------------------------------------------------------
// rct_dpath
// Entry memory, lookup pipeline, fill count and result register of the
// reference count table.
// ---------------------------------------------------------------------------
`default_nettype none

module rct_dpath (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_operation,
    input  wire logic [rct_pkg::ID_W-1:0]       i_object_id,
    input  wire rct_pkg::t_cmd                  i_cmd,
    output rct_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [rct_pkg::STATUS_W-1:0]        o_status,
    output logic [rct_pkg::CNT_W-1:0]           o_use_count
);

    // entry memory, one write and one registered read per cycle
    rct_pkg::t_entry mem [rct_pkg::TABLE_DEPTH];

    logic                          r_op;
    logic [rct_pkg::ID_W-1:0]      r_id;
    logic [rct_pkg::USED_W-1:0]    r_used;
    logic [rct_pkg::USED_W-1:0]    r_scan_idx;
    logic                          r_chk;
    logic [rct_pkg::IDX_W-1:0]     r_chk_idx;
    logic [rct_pkg::IDX_W-1:0]     r_slot;
    logic [rct_pkg::CNT_W-1:0]     r_cnt;
    logic [rct_pkg::CNT_W-1:0]     r_res_cnt;
    rct_pkg::t_entry               r_rd;
    logic                          r_out_valid;
    logic [rct_pkg::STATUS_W-1:0]  r_out_status;
    logic [rct_pkg::CNT_W-1:0]     r_out_count;

    logic                          scan_issue;
    logic                          hit;
    logic [rct_pkg::USED_W-1:0]    last_full;
    logic [rct_pkg::IDX_W-1:0]     last_idx;
    logic [rct_pkg::IDX_W-1:0]     rd_addr;
    logic [rct_pkg::IDX_W-1:0]     wr_addr;
    logic                          wr_en;
    rct_pkg::t_entry               wr_data;
    logic [rct_pkg::CNT_W-1:0]     inc_cnt;
    logic [rct_pkg::CNT_W-1:0]     dec_cnt;
    logic                          out_free;

    // lookup control
    assign scan_issue = i_cmd.scan_step && (r_scan_idx < r_used);
    assign hit        = r_chk && (r_rd.id == r_id);
    assign last_full  = r_used - rct_pkg::USED_W'(1);
    assign last_idx   = last_full[rct_pkg::IDX_W-1:0];

    // count arithmetic
    assign inc_cnt = (r_cnt == rct_pkg::COUNT_MAX) ? r_cnt : r_cnt + rct_pkg::CNT_W'(1);
    assign dec_cnt = r_cnt - rct_pkg::CNT_W'(1);

    assign out_free = !r_out_valid || !i_out_stall;

    // memory port selection
    always_comb begin
        rd_addr = i_cmd.rd_last ? last_idx : r_scan_idx[rct_pkg::IDX_W-1:0];
        wr_en   = i_cmd.wr_inc || i_cmd.wr_dec || i_cmd.wr_new || i_cmd.wr_move;
        wr_addr = i_cmd.wr_new ? r_used[rct_pkg::IDX_W-1:0] : r_slot;
        wr_data = '{id: r_id, cnt: rct_pkg::CNT_W'(1)};
        if (i_cmd.wr_inc) begin
            wr_data.cnt = inc_cnt;
        end else if (i_cmd.wr_dec) begin
            wr_data.cnt = dec_cnt;
        end else if (i_cmd.wr_move) begin
            wr_data = r_rd;
        end
    end

    // memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    // request capture, lookup pipeline and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_scan_idx <= '0;
            r_chk      <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_scan_idx <= '0;
                r_chk      <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_chk <= scan_issue;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + rct_pkg::USED_W'(1);
                end
            end
            if (i_cmd.wr_new) begin
                r_used <= r_used + rct_pkg::USED_W'(1);
            end else if (i_cmd.wr_move) begin
                r_used <= last_full;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_id <= i_object_id;
        end
        if (i_cmd.scan_step) begin
            r_chk_idx <= r_scan_idx[rct_pkg::IDX_W-1:0];
        end
        if (i_cmd.scan_step && hit) begin
            r_slot <= r_chk_idx;
            r_cnt  <= r_rd.cnt;
        end
        if (i_cmd.wr_inc) begin
            r_res_cnt <= inc_cnt;
        end else if (i_cmd.wr_dec) begin
            r_res_cnt <= dec_cnt;
        end else if (i_cmd.wr_new) begin
            r_res_cnt <= rct_pkg::CNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_status <= i_cmd.emit_status;
            r_out_count  <= (i_cmd.emit_status == rct_pkg::ST_COUNTED) ? r_res_cnt : '0;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.in_id_zero = (i_object_id == '0);
        o_stat.is_release = (r_op == rct_pkg::OP_RELEASE);
        o_stat.hit        = hit;
        o_stat.miss       = !r_chk && (r_scan_idx >= r_used);
        o_stat.full       = (r_used >= rct_pkg::USED_W'(rct_pkg::TABLE_DEPTH));
        o_stat.cnt_gt1    = (r_cnt > rct_pkg::CNT_W'(1));
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_use_count = r_out_count;

endmodule

`default_nettype wire

### hdl/rct_ctrl.sv
// ---------------------------------------------------------------------------
// rct_ctrl
// Request sequencer of the reference count table: lookup, update or free,
// then hand the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rct_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire rct_pkg::t_stat i_stat,
    output rct_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_MOVE,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_state           n_state;
    rct_pkg::t_status r_status;
    rct_pkg::t_status n_status;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.emit_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_id_zero) begin
                        n_status = rct_pkg::ST_ZERO_ID;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    n_state = S_DECIDE;
                end else if (i_stat.miss) begin
                    n_state = S_EMIT;
                    if (i_stat.is_release) begin
                        n_status = rct_pkg::ST_NOT_TRACKED;
                    end else if (i_stat.full) begin
                        n_status = rct_pkg::ST_FULL;
                    end else begin
                        o_cmd.wr_new = 1'b1;
                        n_status     = rct_pkg::ST_COUNTED;
                    end
                end
            end
            S_DECIDE: begin
                if (!i_stat.is_release) begin
                    o_cmd.wr_inc = 1'b1;
                    n_status     = rct_pkg::ST_COUNTED;
                    n_state      = S_EMIT;
                end else if (i_stat.cnt_gt1) begin
                    o_cmd.wr_dec = 1'b1;
                    n_status     = rct_pkg::ST_COUNTED;
                    n_state      = S_EMIT;
                end else begin
                    o_cmd.rd_last = 1'b1;
                    n_state       = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.wr_move = 1'b1;
                n_status      = rct_pkg::ST_FREED;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and status code
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= rct_pkg::ST_COUNTED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

### tb/sv/reference_count_table_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reference_count_table_checker
// Watches the request and result channels of the reference count table.
// Every accepted request is run through a local copy of the id/count table
// to work out its status and count. Every accepted result is compared with
// the oldest outstanding prediction. Mismatches, results with nothing
// outstanding and the number of outstanding predictions go to the top.
// ---------------------------------------------------------------------------

module reference_count_table_checker
    import rct_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire logic                i_operation,
    input  wire logic [ID_W-1:0]     i_object_id,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic [CNT_W-1:0]    i_use_count,
    output int                       o_fail_count,
    output int                       o_pending
);

    typedef struct {
        t_status          status;
        logic [CNT_W-1:0] count;
    } count_result_t;

    // local copy of the tracked ids and their counts
    logic [ID_W-1:0]  tracked_id  [TABLE_DEPTH];
    logic [CNT_W-1:0] tracked_cnt [TABLE_DEPTH];
    int               live_entries;

    count_result_t    outstanding_q [$];
    count_result_t    predicted;
    count_result_t    oldest;
    int               i;

    // apply one request to the local table and give the answer it causes
    function automatic void apply_request(input logic op, input logic [ID_W-1:0] id,
                                          output count_result_t res);
        int slot;
        int k;
        int tail;
        slot = -1;
        res.status = ST_COUNTED;
        res.count  = '0;
        if (id == '0) begin
            res.status = ST_ZERO_ID;
            return;
        end
        for (k = 0; k < live_entries; k++) begin
            if (slot < 0 && tracked_id[k] == id) slot = k;
        end
        if (op == OP_ADD) begin
            if (slot >= 0) begin
                if (tracked_cnt[slot] != COUNT_MAX) tracked_cnt[slot] = tracked_cnt[slot] + 1'b1;
                res.count = tracked_cnt[slot];
            end else if (live_entries >= TABLE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                tracked_id[live_entries]  = id;
                tracked_cnt[live_entries] = CNT_W'(1);
                live_entries++;
                res.count = CNT_W'(1);
            end
        end else if (slot < 0) begin
            res.status = ST_NOT_TRACKED;
        end else if (tracked_cnt[slot] > 1) begin
            tracked_cnt[slot] = tracked_cnt[slot] - 1'b1;
            res.count = tracked_cnt[slot];
        end else begin
            // free: last live entry fills the hole, its old slot is cleared
            tail = live_entries - 1;
            tracked_id[slot]  = tracked_id[tail];
            tracked_cnt[slot] = tracked_cnt[tail];
            tracked_id[tail]  = '0;
            tracked_cnt[tail] = '0;
            live_entries = tail;
            res.status = ST_FREED;
        end
    endfunction

    // result transfer checked before the request transfer of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (i = 0; i < TABLE_DEPTH; i++) begin
                tracked_id[i]  = '0;
                tracked_cnt[i] = '0;
            end
            live_entries = 0;
            outstanding_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outstanding_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result with nothing outstanding, got status %0d count %0d",
                             $time, i_status, i_use_count);
                end else begin
                    oldest = outstanding_q.pop_front();
                    if (i_status !== oldest.status) begin
                        o_fail_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, oldest.status, i_status);
                    end
                    if (i_use_count !== oldest.count) begin
                        o_fail_count++;
                        $display("%0t: use count mismatch, expected %0d, got %0d",
                                 $time, oldest.count, i_use_count);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_request(i_operation, i_object_id, predicted);
                outstanding_q.push_back(predicted);
            end
        end
        o_pending = outstanding_q.size();
    end

endmodule

### tb/sv/reference_count_table_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reference_count_table_tb
// Drives add and release requests into the reference count table: zero ids,
// untracked releases, frees with entry moves, a full table and its drain,
// then random traffic over id pools of several sizes. Both channels idle at
// random; the result side holds off once for a long stretch so the block
// backs up. Checking is done by the checker beside the block.
// ---------------------------------------------------------------------------

module reference_count_table_tb;
    import rct_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int HOLD_OFF       = 300;
    localparam int POOL_SIZE      = 200;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            in_valid;
    logic            in_stall;
    logic            operation;
    logic [ID_W-1:0] object_id;
    logic            out_valid;
    logic            out_stall;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    use_count;

    int  fail_count;
    int  pending;
    int  quiet_cycles = 0;

    bit  quick    = 1'b0;   // no idling on either side
    bit  squeeze  = 1'b0;   // long result hold-off requested
    bit  squeezed = 1'b0;
    int  tx_run = 0, rx_run = 0;
    bit  tx_idle = 1'b0, rx_idle = 1'b0;

    logic [ID_W-1:0] id_pool [POOL_SIZE];

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    reference_count_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_operation (operation),
        .i_object_id (object_id),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_use_count (use_count)
    );

    reference_count_table_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_operation  (operation),
        .i_object_id  (object_id),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_use_count  (use_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle cycles before a transfer, in runs with and without idling
    function automatic int draw_wait(inout int run_left, inout bit idle_on);
        if (run_left == 0) begin
            idle_on  = ($urandom_range(0, 3) != 0);
            run_left = $urandom_range(10, 60);
        end
        run_left--;
        return (idle_on && !quick) ? $urandom_range(0, 12) : 0;
    endfunction

    // one request transfer, returns at the falling edge after acceptance
    task automatic send_request(input logic op, input logic [ID_W-1:0] id);
        int gap;
        gap = draw_wait(tx_run, tx_idle);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        object_id <= id;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random traffic over the first pool_n ids of the pool
    task automatic random_requests(input int n, input int pool_n, input int add_pct);
        int k;
        int r;
        logic [ID_W-1:0] id;
        logic op;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 4) id = '0;
            else if (r < 12) id = $urandom;
            else id = id_pool[$urandom_range(0, pool_n - 1)];
            op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_RELEASE;
            send_request(op, id);
        end
    endtask

    // result side: random stalls, one long hold-off when asked
    initial begin : result_sink
        int hold;
        out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            if (squeeze && !squeezed) begin
                squeezed = 1'b1;
                hold = HOLD_OFF;
            end else begin
                hold = draw_wait(rx_run, rx_idle);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("reference_count_table_tb: errors");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin : request_source
        int k;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        operation = OP_ADD;
        object_id = '0;
        for (k = 0; k < POOL_SIZE; k++) begin
            do id_pool[k] = $urandom; while (id_pool[k] == '0);
        end
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero id on both operations, release on an empty table
        send_request(OP_ADD, '0);
        send_request(OP_RELEASE, '0);
        send_request(OP_RELEASE, 32'h0000_0001);

        // counting up and down, frees of the last live slot, release of a freed id
        send_request(OP_ADD, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'h8000_0000);
        send_request(OP_ADD, 32'hFFFF_FFFF);
        send_request(OP_RELEASE, 32'hFFFF_FFFF);
        send_request(OP_RELEASE, 32'h8000_0000);
        send_request(OP_RELEASE, 32'hFFFF_FFFF);
        send_request(OP_RELEASE, 32'hFFFF_FFFF);
        send_request(OP_ADD, 32'h0000_0001);
        send_request(OP_RELEASE, 32'h0000_0001);

        // fill the table flat out, then adds while full, then drain scrambled
        quick = 1'b1;
        for (k = 0; k < TABLE_DEPTH; k++) send_request(OP_ADD, 32'h5A00_0001 | (k << 4));
        quick = 1'b0;
        send_request(OP_ADD, 32'h5A00_0002);
        send_request(OP_ADD, 32'h7FFF_FFFE);
        for (k = 0; k < TABLE_DEPTH; k++)
            send_request(OP_RELEASE, 32'h5A00_0001 | (((k * 37) % TABLE_DEPTH) << 4));

        // random traffic, long result hold-off near the start
        squeeze = 1'b1;
        random_requests(100, POOL_SIZE, 75);
        random_requests(100, POOL_SIZE, 30);
        random_requests(90, 8, 50);
        random_requests(90, 48, 55);
        in_valid <= 1'b0;

        // let the last results come out
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("reference_count_table_tb: clean");
        end else begin
            $display("reference_count_table_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/rct_pkg.sv
hdl/rct_dpath.sv
hdl/rct_ctrl.sv
hdl/reference_count_table.sv
tb/sv/reference_count_table_checker.sv
tb/sv/reference_count_table_tb.sv
